// ===== rtl/block_move_compare_step_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for block_move_compare_step
// Concurrent property wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MOVE_COMPARE_STEP_DEFINES_SVH
`define BLOCK_MOVE_COMPARE_STEP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BMCS_ASSERT_IMP(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error("block_move_compare_step: check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BMCS_ASSERT_NXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error("block_move_compare_step: check failed");

`else

`define BMCS_ASSERT_IMP(label, clock, rst_n, ante, cons)
`define BMCS_ASSERT_NXT(label, clock, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Block move/compare step package
// Action bit positions, flag bit positions and the payload types of the
// input and result stages.
// ----------------------------------------------------------------------------
package bmcs_pkg;

	// Action encoding: each bit selects one property of the instruction.
	localparam int unsigned ACT_DOWN_BIT = 0;  // HL/DE step down
	localparam int unsigned ACT_CMP_BIT  = 1;  // compare form
	localparam int unsigned ACT_REP_BIT  = 2;  // repeating form

	typedef logic [2:0] action_t;

	// Flag register bit positions (S Z F5 H F3 PV N C).
	localparam int unsigned FLAG_C_BIT  = 0;
	localparam int unsigned FLAG_N_BIT  = 1;
	localparam int unsigned FLAG_PV_BIT = 2;
	localparam int unsigned FLAG_F3_BIT = 3;
	localparam int unsigned FLAG_H_BIT  = 4;
	localparam int unsigned FLAG_F5_BIT = 5;
	localparam int unsigned FLAG_Z_BIT  = 6;
	localparam int unsigned FLAG_S_BIT  = 7;

	// Step constants for the 16-bit register pairs.
	localparam logic [15:0] STEP_UP   = 16'h0001;
	localparam logic [15:0] STEP_DOWN = 16'hFFFF;
	localparam logic [15:0] PC_REWIND = 16'h0002;

	// One input word as held in the input register.
	typedef struct packed {
		action_t     action;
		logic [15:0] hl;
		logic [15:0] de;
		logic [15:0] bc;
		logic [7:0]  acc;
		logic [7:0]  flags;
		logic [15:0] pc;
		logic [7:0]  mem_byte;
	} in_word_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic        write_enable;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic [15:0] hl;
		logic [15:0] de;
		logic [15:0] bc;
		logic [7:0]  flags;
		logic [15:0] memptr;
		logic [15:0] pc;
		logic        repeat_res;
	} res_word_t;

endpackage

// ===== rtl/block_move_compare_step.sv =====
// Flow: an accepted word goes through the input register, then the output register.
// Throughput: one word per cycle while out_stall is low; the two registers form
// a two-stage pipeline, so the input takes one more word while a result waits.
// Reset: arst_n clears both stage valid bits at once; payload registers keep junk.
// ----------------------------------------------------------------------------
// Block move/compare step
// One iteration of a block transfer or block compare instruction: updates
// HL, DE, BC, flags, MEMPTR and PC and, for a transfer, produces the memory write.
// ----------------------------------------------------------------------------
`include "block_move_compare_step_defines.svh"

module block_move_compare_step (
	input  logic              clk,
	input  logic              arst_n,
	// Input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  bmcs_pkg::action_t action,
	input  logic [15:0]       hl_in,
	input  logic [15:0]       de_in,
	input  logic [15:0]       bc_in,
	input  logic [7:0]        acc_in,
	input  logic [7:0]        flags_in,
	input  logic [15:0]       pc_in,
	input  logic [7:0]        mem_byte,
	// Output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              write_enable,
	output logic [15:0]       write_addr,
	output logic [7:0]        write_data,
	output logic [15:0]       hl_out,
	output logic [15:0]       de_out,
	output logic [15:0]       bc_out,
	output logic [7:0]        flags_out,
	output logic [15:0]       memptr_out,
	output logic [15:0]       pc_out,
	output logic              repeat_res
);
	import bmcs_pkg::*;

	logic      valid_s1;
	logic      valid_s2;
	in_word_t  word_s1;
	res_word_t res_s2;
	res_word_t res_next;
	logic      load_s1;
	logic      load_s2;

	// Pipeline control: the output register loads when empty or drained,
	// and the input register loads when empty or moving forward.
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = in_valid && !in_stall;
	assign in_stall = valid_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1 || load_s2) begin
				valid_s1 <= load_s1;
			end
			if (load_s2 || (valid_s2 && !out_stall)) begin
				valid_s2 <= load_s2;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= '{action:   action,
			             hl:       hl_in,
			             de:       de_in,
			             bc:       bc_in,
			             acc:      acc_in,
			             flags:    flags_in,
			             pc:       pc_in,
			             mem_byte: mem_byte};
		end
	end

	// Step logic between the input register and the output register.
	always_comb begin
		logic        down;
		logic        cmp;
		logic        rep;
		logic [15:0] step;
		logic [15:0] bc_dec;
		logic        pv;
		logic [7:0]  diff;
		logic        half;
		logic [7:0]  undoc;
		logic [7:0]  sum;
		logic        loop;

		down   = word_s1.action[ACT_DOWN_BIT];
		cmp    = word_s1.action[ACT_CMP_BIT];
		rep    = word_s1.action[ACT_REP_BIT];
		step   = down ? STEP_DOWN : STEP_UP;
		bc_dec = word_s1.bc - STEP_UP;
		pv     = (bc_dec != 16'h0000);
		diff   = word_s1.acc - word_s1.mem_byte;
		half   = (word_s1.acc[3:0] < word_s1.mem_byte[3:0]);
		undoc  = diff - {7'd0, half};
		sum    = word_s1.acc + word_s1.mem_byte;

		res_next    = '0;
		res_next.hl = word_s1.hl + step;
		res_next.bc = bc_dec;

		if (cmp) begin
			// Compare: flags from A minus the byte, no memory write.
			res_next.de                 = word_s1.de;
			res_next.flags[FLAG_S_BIT]  = diff[7];
			res_next.flags[FLAG_Z_BIT]  = (diff == 8'h00);
			res_next.flags[FLAG_F5_BIT] = undoc[1];
			res_next.flags[FLAG_H_BIT]  = half;
			res_next.flags[FLAG_F3_BIT] = undoc[3];
			res_next.flags[FLAG_PV_BIT] = pv;
			res_next.flags[FLAG_N_BIT]  = 1'b1;
			res_next.flags[FLAG_C_BIT]  = word_s1.flags[FLAG_C_BIT];
			res_next.memptr             = word_s1.pc + STEP_UP + step;
			loop                        = rep && pv && (diff != 8'h00);
		end else begin
			// Transfer: copy the byte to DE, S Z C kept, H N cleared.
			res_next.write_enable       = 1'b1;
			res_next.write_addr         = word_s1.de;
			res_next.write_data         = word_s1.mem_byte;
			res_next.de                 = word_s1.de + step;
			res_next.flags[FLAG_S_BIT]  = word_s1.flags[FLAG_S_BIT];
			res_next.flags[FLAG_Z_BIT]  = word_s1.flags[FLAG_Z_BIT];
			res_next.flags[FLAG_F5_BIT] = sum[1];
			res_next.flags[FLAG_H_BIT]  = 1'b0;
			res_next.flags[FLAG_F3_BIT] = sum[3];
			res_next.flags[FLAG_PV_BIT] = pv;
			res_next.flags[FLAG_N_BIT]  = 1'b0;
			res_next.flags[FLAG_C_BIT]  = word_s1.flags[FLAG_C_BIT];
			res_next.memptr             = word_s1.pc;
			loop                        = rep && pv;
		end

		// A looping step rewinds PC to the instruction and points MEMPTR at its second byte.
		res_next.repeat_res = loop;
		res_next.pc         = word_s1.pc;
		if (loop) begin
			res_next.pc     = word_s1.pc - PC_REWIND;
			res_next.memptr = word_s1.pc - STEP_UP;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = res_s2.write_enable;
	assign write_addr   = res_s2.write_addr;
	assign write_data   = res_s2.write_data;
	assign hl_out       = res_s2.hl;
	assign de_out       = res_s2.de;
	assign bc_out       = res_s2.bc;
	assign flags_out    = res_s2.flags;
	assign memptr_out   = res_s2.memptr;
	assign pc_out       = res_s2.pc;
	assign repeat_res   = res_s2.repeat_res;

	// The input side only stalls while a full output register is held back.
	`BMCS_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, valid_s2 && out_stall)
	// A word taken while the output is free reaches the output register next.
	`BMCS_ASSERT_NXT(a_s2_fill, clk, arst_n, load_s2, out_valid)
	// A transfer result always has H and N cleared.
	`BMCS_ASSERT_IMP(a_xfer_flags, clk, arst_n, out_valid && write_enable,
		!flags_out[FLAG_H_BIT] && !flags_out[FLAG_N_BIT])
	// A looping result always reports a nonzero counter.
	`BMCS_ASSERT_IMP(a_loop_pv, clk, arst_n, out_valid && repeat_res,
		flags_out[FLAG_PV_BIT] && (bc_out != 16'h0000))

endmodule
